FILE: rtl/etsf_pkg.sv
package etsf_pkg;

    // Measurement and drive width (state vector components, Q4.12 at 16 bits)
    localparam int DATA_W   = 16;
    // Gain width and fraction (signed Q4.12)
    localparam int GAIN_W   = 16;
    localparam int GAIN_FRAC = 12;
    // Relative threshold width and fraction (unsigned Q2.14)
    localparam int SIGMA_W  = 16;
    localparam int SIGMA_FRAC = 14;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(4915);

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_00 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_01 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_10 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_11 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = CFG_IDX_W'(4);

    // Derived arithmetic widths
    localparam int SQD_W   = 2 * DATA_W + 1;          // |x - xs|^2 per component
    localparam int SQS_W   = 2 * DATA_W - 1;          // xs^2 per component
    localparam int SIG2_W  = 2 * SIGMA_W;             // sigma^2
    localparam int THR_W   = SIG2_W + SQS_W;          // sigma^2 * xs_i^2
    localparam int ERR_W   = SQD_W + 1;               // summed squared error
    localparam int ERR_SHIFT = 2 * SIGMA_FRAC;        // aligns error with sigma^2 scale
    localparam int CMP_W   = THR_W + 1;               // summed threshold
    localparam int PROD_W  = GAIN_W + DATA_W;         // one gain product
    localparam int ACC_W   = PROD_W + 2;              // negated, rounded sum

    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic        [SIG2_W-1:0]  sig2_t;
    typedef logic        [SQD_W-1:0]   sqd_t;
    typedef logic        [THR_W-1:0]   thr_t;

    // Stage loads handed from the sequencer to each lane
    typedef struct packed {
        logic load_sq;    // squares and gain products
        logic load_thr;   // threshold product and drive
    } lane_ctl_t;

endpackage

FILE: rtl/etsf_lane.sv
module etsf_lane
    import etsf_pkg::*;
(
    input  logic      clk,
    input  lane_ctl_t ctl,
    input  data_t     x_own,      // this lane's measured component
    input  data_t     held_own,   // this lane's sampled component
    input  data_t     x0,
    input  data_t     x1,
    input  gain_t     gain_a,     // gain on component 0
    input  gain_t     gain_b,     // gain on component 1
    input  sig2_t     sigma_sq,
    output sqd_t      err_sq,
    output thr_t      thr_part,
    output data_t     drive
);

    localparam logic signed [DATA_W-1:0] LIM_HI = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] LIM_LO = {1'b1, {(DATA_W-1){1'b0}}};

    sqd_t                      sq_d_reg;
    logic [SQS_W-1:0]          sq_s_reg;
    logic signed [PROD_W-1:0]  prod_a_reg;
    logic signed [PROD_W-1:0]  prod_b_reg;
    thr_t                      thr_reg;
    data_t                     drive_reg;

    logic signed [DATA_W:0]      diff;
    logic signed [2*DATA_W+1:0]  diff_sq;
    logic signed [2*DATA_W-1:0]  held_sq;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-GAIN_FRAC-1:0] quot;
    data_t                       drive_next;

    // stage 1: squares and gain products
    assign diff    = (DATA_W+1)'(x_own) - (DATA_W+1)'(held_own);
    assign diff_sq = diff * diff;
    assign held_sq = held_own * held_own;

    // stage 2: -(Ka*x0 + Kb*x1), round half up, floor, saturate
    assign acc  = -(ACC_W'(prod_a_reg) + ACC_W'(prod_b_reg))
                  + ACC_W'(1 << (GAIN_FRAC - 1));
    assign quot = acc[ACC_W-1:GAIN_FRAC];

    always_comb
    begin
        if (quot > (ACC_W-GAIN_FRAC)'(LIM_HI))
            drive_next = LIM_HI;
        else if (quot < (ACC_W-GAIN_FRAC)'(LIM_LO))
            drive_next = LIM_LO;
        else
            drive_next = quot[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_sq)
        begin
            sq_d_reg   <= diff_sq[SQD_W-1:0];
            sq_s_reg   <= held_sq[SQS_W-1:0];
            prod_a_reg <= gain_a * x0;
            prod_b_reg <= gain_b * x1;
        end
        if (ctl.load_thr)
        begin
            thr_reg   <= sigma_sq * sq_s_reg;
            drive_reg <= drive_next;
        end
    end

    assign err_sq   = sq_d_reg;
    assign thr_part = thr_reg;
    assign drive    = drive_reg;

endmodule

FILE: rtl/etsf_merge.sv
module etsf_merge
    import etsf_pkg::*;
(
    input  sqd_t err_sq_0,
    input  sqd_t err_sq_1,
    input  thr_t thr_part_0,
    input  thr_t thr_part_1,
    input  logic primed,
    output logic fire
);

    logic [ERR_W-1:0] err_sum;
    logic [CMP_W-1:0] thr_sum;
    logic [CMP_W-1:0] lhs;

    assign err_sum = ERR_W'(err_sq_0) + ERR_W'(err_sq_1);
    assign thr_sum = CMP_W'(thr_part_0) + CMP_W'(thr_part_1);
    // error at Q.24 raised to the Q.52 scale of sigma^2 * |xs|^2
    assign lhs     = CMP_W'({err_sum, {ERR_SHIFT{1'b0}}});

    // strict compare: equal error does not trigger
    assign fire = !primed || (lhs > thr_sum);

endmodule

FILE: rtl/event_triggered_state_feedback.sv
// Event-triggered state feedback, relative threshold.
// Slave stream s_*: one beat per sample, tdata = {meas_1, meas_0}.
// Master stream m_*: one beat per sample, tdata = {drive_1, drive_0},
// tuser = event_fired (1 when the sample was taken and the drive recomputed).
// Config channel cfg_*: index 0..3 gains K00, K01, K10, K11 (Q4.12),
// index 4 sigma (Q2.14); other indices ignored. Always ready; write only
// while idle, new values apply from the next sample.
// Path from input beat to output valid: capture, squares and gain
// products, threshold product and drive, then compare and update.
// Samples do not overlap: the two lanes hold their stage registers for
// a single sample, so s_tready drops while a sample is inside.
// A new sample is taken while the previous result still waits on m_tready;
// it then parks in the last stage until the output register frees.
// Reset: gains 0, sigma 4915, held state and drive 0, not primed, so the
// first sample after reset always fires.
module event_triggered_state_feedback
    import etsf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // sample input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*DATA_W-1:0]     s_tdata,   // [meas_0, meas_1] from bit 0
    // drive output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2*DATA_W-1:0]     m_tdata,   // [drive_0, drive_1] from bit 0
    output logic                    m_tuser,   // [event_fired]
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SIGMA_W-1:0]      cfg_data
);

    // configuration
    gain_t               gain_00_reg, gain_01_reg, gain_10_reg, gain_11_reg;
    logic [SIGMA_W-1:0]  sigma_reg;

    // controller state
    data_t  held_0_reg, held_1_reg;
    data_t  held_drive_0_reg, held_drive_1_reg;
    logic   primed_reg;

    // sample pipeline (one sample in flight)
    logic   v1_reg, v2_reg, v3_reg;
    data_t  x0_reg, x1_reg;
    sig2_t  sigma_sq_reg;

    // output register
    logic   out_valid_reg;
    data_t  out_drive_0_reg, out_drive_1_reg;
    logic   out_event_reg;

    lane_ctl_t ctl;
    sqd_t      err_sq_0, err_sq_1;
    thr_t      thr_part_0, thr_part_1;
    data_t     new_drive_0, new_drive_1;
    logic      fire;
    logic      in_beat;
    logic      retire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !(v1_reg || v2_reg || v3_reg);
    assign in_beat   = s_tvalid && s_tready;
    // last stage retires once the output register is free or being emptied
    assign retire    = v3_reg && (!out_valid_reg || m_tready);

    assign ctl.load_sq  = v1_reg;
    assign ctl.load_thr = v2_reg;

    etsf_lane u_lane_0 (
        .clk      (clk),
        .ctl      (ctl),
        .x_own    (x0_reg),
        .held_own (held_0_reg),
        .x0       (x0_reg),
        .x1       (x1_reg),
        .gain_a   (gain_00_reg),
        .gain_b   (gain_01_reg),
        .sigma_sq (sigma_sq_reg),
        .err_sq   (err_sq_0),
        .thr_part (thr_part_0),
        .drive    (new_drive_0)
    );

    etsf_lane u_lane_1 (
        .clk      (clk),
        .ctl      (ctl),
        .x_own    (x1_reg),
        .held_own (held_1_reg),
        .x0       (x0_reg),
        .x1       (x1_reg),
        .gain_a   (gain_10_reg),
        .gain_b   (gain_11_reg),
        .sigma_sq (sigma_sq_reg),
        .err_sq   (err_sq_1),
        .thr_part (thr_part_1),
        .drive    (new_drive_1)
    );

    etsf_merge u_merge (
        .err_sq_0   (err_sq_0),
        .err_sq_1   (err_sq_1),
        .thr_part_0 (thr_part_0),
        .thr_part_1 (thr_part_1),
        .primed     (primed_reg),
        .fire       (fire)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_00_reg <= '0;
            gain_01_reg <= '0;
            gain_10_reg <= '0;
            gain_11_reg <= '0;
            sigma_reg   <= SIGMA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN_00: gain_00_reg <= gain_t'(cfg_data);
                CFG_GAIN_01: gain_01_reg <= gain_t'(cfg_data);
                CFG_GAIN_10: gain_10_reg <= gain_t'(cfg_data);
                CFG_GAIN_11: gain_11_reg <= gain_t'(cfg_data);
                CFG_SIGMA:   sigma_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // pipeline control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
            primed_reg       <= 1'b0;
            held_0_reg       <= '0;
            held_1_reg       <= '0;
            held_drive_0_reg <= '0;
            held_drive_1_reg <= '0;
        end
        else
        begin
            v1_reg <= in_beat;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg || (v3_reg && !retire);

            if (retire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (retire && fire)
            begin
                held_0_reg       <= x0_reg;
                held_1_reg       <= x1_reg;
                held_drive_0_reg <= new_drive_0;
                held_drive_1_reg <= new_drive_1;
                primed_reg       <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            x0_reg <= s_tdata[DATA_W-1:0];
            x1_reg <= s_tdata[2*DATA_W-1:DATA_W];
        end
        if (v1_reg)
            sigma_sq_reg <= sigma_reg * sigma_reg;
        if (retire)
        begin
            out_drive_0_reg <= fire ? new_drive_0 : held_drive_0_reg;
            out_drive_1_reg <= fire ? new_drive_1 : held_drive_1_reg;
            out_event_reg   <= fire;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_drive_1_reg, out_drive_0_reg};
    assign m_tuser  = out_event_reg;

endmodule
